### src/hh4_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the H4 stream deframer.
// Depends on nothing; every module of the block refers to it by scoped names.
package hh4_pkg;

  localparam int HDR_BYTES   = 4;
  localparam int STORE_DEPTH = HDR_BYTES + 1;
  localparam int FIFO_AW     = 3;
  localparam int FIFO_DEPTH  = 1 << FIFO_AW;

  localparam logic [7:0]  TYPE_CMD = 8'd1;
  localparam logic [7:0]  TYPE_ACL = 8'd2;
  localparam logic [7:0]  TYPE_SCO = 8'd3;
  localparam logic [7:0]  TYPE_ISO = 8'd5;

  localparam logic [2:0]  HDR_LEN_CMD  = 3'd3;
  localparam logic [2:0]  HDR_LEN_ACL  = 3'd4;
  localparam logic [2:0]  HDR_LEN_SCO  = 3'd3;
  localparam logic [2:0]  HDR_LEN_ISO  = 3'd4;
  localparam logic [2:0]  HDR_LEN_NONE = 3'd0;

  localparam logic [15:0] ISO_LEN_MASK      = 16'h3FFF;
  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;

  // One queue entry: a whole header burst or a single payload byte.
  typedef struct packed {
    logic [STORE_DEPTH-1:0][7:0] bytes;
    logic [2:0]                  nbytes;
    logic [2:0]                  ptype;
    logic                        first;
    logic                        last;
  } hh4_entry_t;

  function automatic logic [2:0] hdr_len_of(input logic [7:0] b);
    logic [2:0] n;
    unique case (b)
      TYPE_CMD: n = HDR_LEN_CMD;
      TYPE_ACL: n = HDR_LEN_ACL;
      TYPE_SCO: n = HDR_LEN_SCO;
      TYPE_ISO: n = HDR_LEN_ISO;
      default:  n = HDR_LEN_NONE;
    endcase
    if (32'(n) > HDR_BYTES) begin
      n = HDR_LEN_NONE;
    end
    return n;
  endfunction

endpackage

### src/hh4_front.sv
`timescale 1ns / 1ps
// Front end: hunts for type bytes, holds the header, checks the length and
// pushes header bursts and payload bytes into the queue. Uses hh4_pkg.
module hh4_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  input  logic               q_full,
  output logic               q_push,
  output hh4_pkg::hh4_entry_t q_entry
);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HDR  = 2'd1,
    PH_PAY  = 2'd2
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  store [hh4_pkg::STORE_DEPTH];
  logic [2:0]  count, count_next;
  logic [2:0]  size, size_next;
  logic [15:0] payload_left, payload_left_next;
  logic [15:0] max_payload;
  logic        accept;
  logic        size4;
  logic [2:0]  count_inc;
  logic [7:0]  len_lo;
  logic [7:0]  len_hi;
  logic [15:0] len;
  logic [2:0]  hlen;

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  assign size4     = (size == hh4_pkg::HDR_LEN_ACL);
  assign count_inc = count + 3'd1;
  assign len_lo    = size4 ? store[3] : in_byte;
  assign len_hi    = size4 ? in_byte : 8'd0;
  assign hlen      = hh4_pkg::hdr_len_of(in_byte);

  always_comb begin
    unique case (store[0])
      hh4_pkg::TYPE_ACL: len = {len_hi, len_lo};
      hh4_pkg::TYPE_ISO: len = {len_hi, len_lo} & hh4_pkg::ISO_LEN_MASK;
      default:           len = {8'd0, len_lo};
    endcase
  end

  always_comb begin
    phase_next        = phase;
    count_next        = count;
    size_next         = size;
    payload_left_next = payload_left;
    q_push            = 1'b0;
    q_entry           = '0;
    q_entry.ptype     = store[0][2:0];
    if (accept) begin
      unique case (phase)
        PH_HDR: begin
          count_next = count_inc;
          if (count_inc == size + 3'd1) begin
            if (len > max_payload) begin
              phase_next = PH_HUNT;
              count_next = 3'd0;
            end else begin
              q_push           = 1'b1;
              q_entry.bytes[0] = store[0];
              q_entry.bytes[1] = store[1];
              q_entry.bytes[2] = store[2];
              q_entry.bytes[3] = size4 ? store[3] : in_byte;
              q_entry.bytes[4] = in_byte;
              q_entry.nbytes   = count_inc;
              q_entry.first    = 1'b1;
              q_entry.last     = (len == 16'd0);
              if (len == 16'd0) begin
                phase_next = PH_HUNT;
                count_next = 3'd0;
              end else begin
                phase_next        = PH_PAY;
                payload_left_next = len;
              end
            end
          end
        end
        PH_PAY: begin
          q_push            = 1'b1;
          q_entry.bytes[0]  = in_byte;
          q_entry.nbytes    = 3'd1;
          q_entry.last      = (payload_left <= 16'd1);
          payload_left_next = payload_left - 16'd1;
          if (payload_left <= 16'd1) begin
            phase_next        = PH_HUNT;
            count_next        = 3'd0;
            payload_left_next = 16'd0;
          end
        end
        default: begin
          phase_next = PH_HUNT;
          if (hlen != hh4_pkg::HDR_LEN_NONE) begin
            count_next = 3'd1;
            size_next  = hlen;
            phase_next = PH_HDR;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      count        <= 3'd0;
      size         <= 3'd0;
      payload_left <= 16'd0;
      max_payload  <= hh4_pkg::MAX_PAYLOAD_RESET;
    end else begin
      phase        <= phase_next;
      count        <= count_next;
      size         <= size_next;
      payload_left <= payload_left_next;
      if (cfg_valid && cfg_ready) begin
        max_payload <= cfg_data;
      end
    end
  end

  // Hold the type byte and header bytes as they arrive.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (phase == PH_HDR) begin
        if (32'(count) <= hh4_pkg::HDR_BYTES) begin
          store[count] <= in_byte;
        end
      end else if (phase != PH_PAY && hlen != hh4_pkg::HDR_LEN_NONE) begin
        store[0] <= in_byte;
      end
    end
  end

endmodule

### src/hh4_fifo.sv
`timescale 1ns / 1ps
// Short queue of header bursts and payload bytes between front and back end.
// Uses hh4_pkg for the entry type and depth.
module hh4_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  hh4_pkg::hh4_entry_t wr_entry,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output hh4_pkg::hh4_entry_t rd_entry
);

  hh4_pkg::hh4_entry_t mem [hh4_pkg::FIFO_DEPTH];
  logic [hh4_pkg::FIFO_AW-1:0] wr_ptr;
  logic [hh4_pkg::FIFO_AW-1:0] rd_ptr;
  logic [hh4_pkg::FIFO_AW:0]   fill;
  logic                        do_push;
  logic                        do_pop;

  assign full      = (fill == (hh4_pkg::FIFO_AW + 1)'(hh4_pkg::FIFO_DEPTH));
  assign not_empty = (fill != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rd_entry  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

endmodule

### src/hh4_back.sv
`timescale 1ns / 1ps
// Back end: walks each queue entry byte by byte into the output register.
// Uses hh4_pkg for the entry type.
module hh4_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  hh4_pkg::hh4_entry_t q_entry,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic [3:0]          out_user,
  output logic                out_last
);

  logic [2:0] idx;
  logic       load;
  logic       final_byte;

  assign load       = q_valid && (!out_valid || out_ready);
  assign final_byte = (idx + 3'd1 == q_entry.nbytes);
  assign q_pop      = load && final_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 3'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= final_byte ? 3'd0 : idx + 3'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= q_entry.bytes[idx];
      out_user <= {q_entry.first && (idx == 3'd0), q_entry.ptype};
      out_last <= q_entry.last && final_byte;
    end
  end

endmodule

### src/hci_h4_stream_deframer_core.sv
`timescale 1ns / 1ps
// Top level of the H4 stream deframer: front end, queue, back end.
// Depends on hh4_pkg, hh4_front, hh4_fifo and hh4_back.
//
//  channel  | direction | payload
//  s_axis   | in        | tdata[7:0] in_byte
//  m_axis   | out       | tdata[7:0] out_byte, tuser[2:0] pkt_type,
//           |           | tuser[3] frame_start, tlast frame_end
//  cfg      | in        | cfg_data[15:0] max_payload
//
// One input byte per cycle while the queue is not full; a header burst
// of four or five bytes leaves one byte per cycle while m_axis_tready is
// high; payload bytes fill the eight-entry queue, then the output register.
// Reset sets max_payload to 1024 and clears the front phase and queue.
// s_axis_tready drops only while the queue is full.
module hci_h4_stream_deframer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [3:0]  m_axis_tuser,   // [2:0] pkt_type, [3] frame_start
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data        // [15:0] max_payload
);

  hh4_pkg::hh4_entry_t push_entry;
  hh4_pkg::hh4_entry_t head_entry;
  logic                push;
  logic                full;
  logic                pop;
  logic                not_empty;

  hh4_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (full),
    .q_push    (push),
    .q_entry   (push_entry)
  );

  hh4_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_entry  (push_entry),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .rd_entry  (head_entry)
  );

  hh4_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (not_empty),
    .q_entry   (head_entry),
    .q_pop     (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_user  (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

endmodule
